// ----- src/assert_macros.svh -----
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lqs_pkg.sv -----
package lqs_pkg;

  // Width of one stored value.
  localparam int unsigned DATA_W = 32;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_SRCH = 2'd2
  } req_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STS_INSERTED  = 3'd0,
    STS_OVERFLOW  = 3'd1,
    STS_REMOVED   = 3'd2,
    STS_UNDERFLOW = 3'd3,
    STS_FOUND     = 3'd4,
    STS_NOTFOUND  = 3'd5,
    STS_EMPTY     = 3'd6
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;     // latch the search value and start the scan at the head
    logic    enq;      // write the new value and advance the tail
    logic    pop;      // retire the head entry
    logic    step;     // move the scan to the next entry
    logic    scan_rd;  // read address follows the scan instead of the head
    logic    res_vld;  // register a result
    status_e res_code; // status of that result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;  // queue holds nothing
    logic full;   // tail sits on the last slot
    logic hit;    // entry under the scan matches the search value
    logic last;   // entry under the scan is the tail
  } sts_t;

endpackage

// ----- src/linear_queue_with_search.sv -----
// Linear array queue with search. A request is taken when start_i is high and
// busy_o is low; each request other than the undefined code gives exactly one
// result, shown for one cycle with valid_o high, and the receiver cannot hold
// it off. An enqueue, and any request that fails at once (overflow, underflow,
// empty), is answered with busy_o staying low. A dequeue waits in its S_DEQ
// state, with busy_o high, for the registered read of the head slot. A search
// compares n entries, at most DEPTH, one after another, because the
// single read port of the slot memory delivers one entry per cycle. The slot
// memory needs no clearing pass after reset.
`include "assert_macros.svh"

module linear_queue_with_search #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        req_type_i,
  input  logic signed [lqs_pkg::DATA_W-1:0] value_i,
  output logic                              valid_o,
  output logic [2:0]                        status_o,
  output logic signed [lqs_pkg::DATA_W-1:0] data_o,
  output logic [$clog2(DEPTH+1)-1:0]        position_o
);
  import lqs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller.
  lqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  // Datapath with the slot memory.
  lqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .value_i    (value_i),
    .sts_o      (sts),
    .valid_o    (valid_o),
    .status_o   (status_o),
    .data_o     (data_o),
    .position_o (position_o)
  );

  // A result transfer only ever happens once the controller is back at rest.
  `ASSERT_SAME(a_res_not_busy, clk_i, rst_ni, valid_o, !busy_o, "result while busy")

  // A defined request either gives its result next cycle or keeps the block busy.
  `ASSERT_NEXT(a_req_progress, clk_i, rst_ni,
               start_i && !busy_o && (req_type_i == REQ_ENQ || req_type_i == REQ_DEQ ||
                                      req_type_i == REQ_SRCH),
               valid_o || busy_o, "request neither answered nor in progress")

  // A match always carries a non-zero position.
  `ASSERT_SAME(a_found_pos, clk_i, rst_ni, valid_o && (status_o == STS_FOUND),
               position_o != '0, "found result with zero position")

endmodule

// ----- src/lqs_ctrl.sv -----
module lqs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    req_type_i,
  input  lqs_pkg::sts_t sts_i,
  output lqs_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import lqs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DEQ  = 3'b010,
    S_SRCH = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (req_type_i)
            REQ_ENQ: begin
              cmd_o.res_vld = 1'b1;
              if (sts_i.empty || !sts_i.full) begin
                cmd_o.enq      = 1'b1;
                cmd_o.res_code = STS_INSERTED;
              end else begin
                cmd_o.res_code = STS_OVERFLOW;
              end
            end
            REQ_DEQ: begin
              if (sts_i.empty) begin
                cmd_o.res_vld  = 1'b1;
                cmd_o.res_code = STS_UNDERFLOW;
              end else begin
                state_d = S_DEQ;
              end
            end
            REQ_SRCH: begin
              if (sts_i.empty) begin
                cmd_o.res_vld  = 1'b1;
                cmd_o.res_code = STS_EMPTY;
              end else begin
                cmd_o.load = 1'b1;
                state_d    = S_SRCH;
              end
            end
            default: begin
              // An undefined request is dropped without a result.
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_DEQ: begin
        // The head entry has been read; return it and retire it.
        cmd_o.res_vld  = 1'b1;
        cmd_o.res_code = STS_REMOVED;
        cmd_o.pop      = 1'b1;
        state_d        = S_IDLE;
      end
      S_SRCH: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.hit) begin
          cmd_o.res_vld  = 1'b1;
          cmd_o.res_code = STS_FOUND;
          state_d        = S_IDLE;
        end else if (sts_i.last) begin
          cmd_o.res_vld  = 1'b1;
          cmd_o.res_code = STS_NOTFOUND;
          state_d        = S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/lqs_dp.sv -----
module lqs_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lqs_pkg::cmd_t                       cmd_i,
  input  logic signed [lqs_pkg::DATA_W-1:0]   value_i,
  output lqs_pkg::sts_t                       sts_o,
  output logic                                valid_o,
  output logic [2:0]                          status_o,
  output logic signed [lqs_pkg::DATA_W-1:0]   data_o,
  output logic [$clog2(DEPTH+1)-1:0]          position_o
);
  import lqs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] value_q;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     tail_q, tail_d;
  logic              empty_q, empty_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic              valid_q;
  logic [2:0]        status_q;
  logic [DATA_W-1:0] data_q;
  logic [PW-1:0]     pos_q;
  logic [PW-1:0]     pos_calc;

  // Status towards the controller.
  assign sts_o.empty  = empty_q;
  assign sts_o.full   = (tail_q == AW'(DEPTH - 1));
  assign sts_o.hit    = (rdata_q == value_q);
  assign sts_o.last   = (cur_q == tail_q);

  // Read address: the head when not scanning, the entry after the current one when scanning.
  assign raddr = cmd_i.scan_rd ? (cur_q + AW'(1)) : head_q;
  // An enqueue into an empty queue restarts at slot zero.
  assign waddr = empty_q ? '0 : (tail_q + AW'(1));

  // Queue storage with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq) begin
      mem[waddr] <= value_i;
    end
    rdata_q <= mem[raddr];
  end

  // Pointer and scan updates.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    cur_d   = cur_q;
    if (cmd_i.enq) begin
      if (empty_q) begin
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b0;
      end else begin
        tail_d = waddr;
      end
    end
    if (cmd_i.pop) begin
      if (head_q == tail_q) begin
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b1;
      end else begin
        head_d = head_q + AW'(1);
      end
    end
    if (cmd_i.load) begin
      cur_d = head_q;
    end else if (cmd_i.step) begin
      cur_d = cur_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  // Scan position and search value carry no reset.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.load) begin
      value_q <= value_i;
    end
  end

  // One-based distance of the current entry from the head.
  assign pos_calc = PW'(cur_q) - PW'(head_q) + PW'(1);

  // Result register: the strobe is reset, the payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_vld) begin
      status_q <= cmd_i.res_code;
      data_q   <= (cmd_i.res_code == STS_REMOVED) ? rdata_q : '0;
      pos_q    <= (cmd_i.res_code == STS_FOUND) ? pos_calc : '0;
    end
  end

  assign valid_o    = valid_q;
  assign status_o   = status_q;
  assign data_o     = data_q;
  assign position_o = pos_q;

endmodule

// ----- test/tb_linear_queue_with_search.sv -----
`timescale 1ns / 1ps

module tb_linear_queue_with_search;
  import lqs_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned POS_W = $clog2(DEPTH + 1);
  localparam int unsigned RANDOM_TARGET = 1130;
  // The one request code that the block drops without a result.
  localparam logic [1:0] REQ_UNDEF = 2'd3;
  // A value that no other random pick is meant to hit, placed in the last slot.
  localparam logic signed [DATA_W-1:0] TAIL_MARKER = 32'sh2468ACE1;
  localparam logic signed [DATA_W-1:0] MISSING_VALUE = 32'sh0BADF00D;

  typedef struct {
    logic [1:0]                 kind;
    logic signed [DATA_W-1:0]   val;
    int unsigned                idle_pct;
  } lqs_request_t;

  typedef struct {
    status_e                    status;
    logic signed [DATA_W-1:0]   data;
    logic [POS_W-1:0]           pos;
  } lqs_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic [1:0]                 req_type_i = REQ_ENQ;
  logic signed [DATA_W-1:0]   value_i = '0;
  logic                       busy_o;
  logic                       valid_o;
  logic [2:0]                 status_o;
  logic signed [DATA_W-1:0]   data_o;
  logic [POS_W-1:0]           position_o;

  lqs_request_t request_queue[$];
  lqs_result_t  pending_results[$];
  int unsigned  accepted_count = 0;
  int unsigned  mismatch_count = 0;

  // Shadow copy of the queue contents and its indexes.
  logic signed [DATA_W-1:0] q_slots[DEPTH];
  int unsigned              q_head = 0;
  int unsigned              q_tail = 0;
  bit                       q_empty = 1'b1;

  linear_queue_with_search #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .req_type_i(req_type_i),
    .value_i(value_i),
    .valid_o(valid_o),
    .status_o(status_o),
    .data_o(data_o),
    .position_o(position_o)
  );

  always #10 clk_i = ~clk_i;

  // Updates the shadow queue for one accepted request and records the result it should give.
  task automatic apply_request(input logic [1:0] kind, input logic signed [DATA_W-1:0] val);
    lqs_result_t r;
    int unsigned i;
    bit          seen;
    r.status = STS_INSERTED;
    r.data   = '0;
    r.pos    = '0;
    seen     = 1'b0;
    case (kind)
      REQ_ENQ: begin
        if (q_empty) begin
          q_head     = 0;
          q_tail     = 0;
          q_slots[0] = val;
          q_empty    = 1'b0;
        end else if (q_tail == DEPTH - 1) begin
          r.status = STS_OVERFLOW;
        end else begin
          q_tail          = q_tail + 1;
          q_slots[q_tail] = val;
        end
      end
      REQ_DEQ: begin
        if (q_empty) begin
          r.status = STS_UNDERFLOW;
        end else begin
          r.status = STS_REMOVED;
          r.data   = q_slots[q_head];
          // Taking the last entry rewinds the storage to the first slot.
          if (q_head >= q_tail) begin
            q_head  = 0;
            q_tail  = 0;
            q_empty = 1'b1;
          end else begin
            q_head = q_head + 1;
          end
        end
      end
      REQ_SRCH: begin
        if (q_empty) begin
          r.status = STS_EMPTY;
        end else begin
          r.status = STS_NOTFOUND;
          for (i = q_head; i <= q_tail; i++) begin
            if (!seen && q_slots[i] == val) begin
              seen     = 1'b1;
              r.status = STS_FOUND;
              r.pos    = POS_W'(i - q_head + 1);
            end
          end
        end
      end
      default: begin
        return;
      end
    endcase
    pending_results.push_back(r);
  endtask

  task automatic add_request(input logic [1:0] kind, input logic signed [DATA_W-1:0] val,
                             input int unsigned idle_pct);
    lqs_request_t req;
    req.kind     = kind;
    req.val      = val;
    req.idle_pct = idle_pct;
    request_queue.push_back(req);
  endtask

  // Values lean on a small set so that searches often hit, with extremes and full noise mixed in.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      4, 5, 6, 7: return DATA_W'(100 + $urandom_range(0, 5));
      default: return $urandom();
    endcase
  endfunction

  // Driver: presents queued requests and holds each one until its transfer completes.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    lqs_request_t nxt;
    if (!rst_ni) begin
      start_i    <= 1'b0;
      req_type_i <= REQ_ENQ;
      value_i    <= '0;
    end else begin
      if (start_i && !busy_o) begin
        apply_request(req_type_i, value_i);
        accepted_count++;
      end
      // A new request may be offered only once the current one has been taken.
      if (!start_i || !busy_o) begin
        if (request_queue.size() != 0 &&
            $urandom_range(0, 99) >= request_queue[0].idle_pct) begin
          nxt = request_queue.pop_front();
          start_i    <= 1'b1;
          req_type_i <= nxt.kind;
          value_i    <= nxt.val;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result strobe is matched against the oldest outstanding expectation.
  always @(posedge clk_i) begin : observe
    lqs_result_t exp_r;
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d data %0d position %0d",
               status_o, data_o, position_o);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          mismatch_count++;
        end
        if (data_o !== exp_r.data) begin
          $error("data: expected %0d, got %0d", exp_r.data, data_o);
          mismatch_count++;
        end
        if (position_o !== exp_r.pos) begin
          $error("position: expected %0d, got %0d", exp_r.pos, position_o);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus, end-of-run wait and the verdict.
  initial begin : stimulus
    int unsigned round;
    int unsigned seg_len;
    int unsigned k;
    int unsigned roll;
    int unsigned gap_pct;
    int unsigned random_count;
    int unsigned total_requests;
    bit          filling;

    // Directed part: empty-queue failures, extremes, the dropped code and a full drain.
    add_request(REQ_DEQ, $urandom(), 0);
    add_request(REQ_SRCH, $urandom(), 0);
    add_request(REQ_UNDEF, $urandom(), 0);
    add_request(REQ_ENQ, 32'sh7FFFFFFF, 0);
    add_request(REQ_ENQ, 32'sh80000000, 0);
    add_request(REQ_ENQ, '0, 0);
    add_request(REQ_ENQ, -32'sd1, 0);
    add_request(REQ_SRCH, 32'sh80000000, 0);
    add_request(REQ_SRCH, 32'sd12345, 0);
    add_request(REQ_UNDEF, 32'sh7FFFFFFF, 0);
    add_request(REQ_SRCH, 32'sh7FFFFFFF, 0);
    add_request(REQ_DEQ, '0, 0);
    add_request(REQ_SRCH, -32'sd1, 0);
    add_request(REQ_DEQ, '0, 0);
    add_request(REQ_DEQ, '0, 0);
    add_request(REQ_DEQ, -32'sd1, 0);
    add_request(REQ_DEQ, '0, 0);
    add_request(REQ_ENQ, 32'sd7, 0);
    add_request(REQ_SRCH, 32'sd7, 0);
    add_request(REQ_DEQ, '0, 0);

    // Fill every slot, hit the last position, then overflow with the head moved on.
    random_count = 0;
    for (k = 0; k < DEPTH - 1; k++) begin
      add_request(REQ_ENQ, pick_value(), 0);
    end
    add_request(REQ_ENQ, TAIL_MARKER, 0);
    add_request(REQ_ENQ, pick_value(), 0);
    add_request(REQ_SRCH, TAIL_MARKER, 0);
    add_request(REQ_SRCH, MISSING_VALUE, 0);
    add_request(REQ_DEQ, pick_value(), 0);
    add_request(REQ_ENQ, pick_value(), 0);
    random_count = DEPTH + 5;

    // Random part: alternating fill and drain stretches, each stretch with its own idle rate.
    round = 0;
    while (random_count < RANDOM_TARGET) begin
      case (round % 3)
        0: gap_pct = 0;
        1: gap_pct = 80;
        default: gap_pct = 37;
      endcase
      filling = (round % 2 == 0);
      seg_len = $urandom_range(10, 90);
      for (k = 0; k < seg_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          add_request(REQ_UNDEF, $urandom(), gap_pct);
        end else begin
          if (roll < 68) begin
            add_request(filling ? REQ_ENQ : REQ_DEQ, pick_value(), gap_pct);
          end else if (roll < 88) begin
            add_request(REQ_SRCH, pick_value(), gap_pct);
          end else begin
            add_request(filling ? REQ_DEQ : REQ_ENQ, pick_value(), gap_pct);
          end
          random_count++;
        end
      end
      round++;
    end
    total_requests = request_queue.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every transfer, then for every result, then for any trailing activity.
    while (accepted_count < total_requests) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
